### hdl/tblt_pkg.sv
// Package for the timed block list table: action codes, status codes, sizes.
// Used by the channel interfaces, the table RAM wrapper users and the top level.
package tblt_pkg;

  localparam int unsigned TBLT_CAPACITY = 64;

  localparam int unsigned ID_W   = 32;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned NOW_W  = 31;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned STAT_W = 3;

  localparam logic [ACT_W-1:0] ACT_ADD_ABS = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ADD_REL = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd3;

  localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STAT_W-1:0] ST_UPDATED = 3'd1;
  localparam logic [STAT_W-1:0] ST_IGNORED = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FOUND   = 3'd4;
  localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd5;

  // permanent marker for relative adds, and the saturation ceiling
  localparam logic signed [TIME_W-1:0] TIME_PERM_REL = -32'sd1;
  localparam logic signed [TIME_W-1:0] TIME_MAX      = 32'sh7FFF_FFFF;

endpackage

### hdl/tblt_req_if.sv
// Request channel of the timed block list table: valid/ready plus one item.
// Depends on tblt_pkg for field widths.
interface tblt_req_if import tblt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic signed [ID_W-1:0]   entry_id;
  logic signed [TIME_W-1:0] time_value;
  logic [NOW_W-1:0]         current_time;

  modport source (output valid, action, entry_id, time_value, current_time, input ready);
  modport sink   (input valid, action, entry_id, time_value, current_time, output ready);
endinterface

### hdl/tblt_rsp_if.sv
// Response channel of the timed block list table: valid/ready plus one item.
// Depends on tblt_pkg for field widths.
interface tblt_rsp_if import tblt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              is_blocked;
  logic [STAT_W-1:0] status;

  modport source (output valid, is_blocked, status, input ready);
  modport sink   (input valid, is_blocked, status, output ready);
endinterface

### hdl/tblt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tblt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/timed_block_list_table_unit.sv
// Timed block list table, top level. Depends on tblt_pkg, tblt_req_if, tblt_rsp_if, tblt_ram.
// Sequence: request accept, PREP, TEST, then per table entry visited one RAM read (RD)
//   and one check/write (CHK), then RESP loads the result register.
// Throughput: one item at a time; the next item is accepted once back in IDLE after the result
//   register loads. Set by the single RAM port pair the scan walks.
// Reset: entry count and control clear at once; the table RAM is not cleared.
module timed_block_list_table_unit import tblt_pkg::*; #(
  parameter int unsigned CAPACITY = TBLT_CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tblt_req_if.sink   req_i,
  tblt_rsp_if.source rsp_o
);

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned ENT_W = ID_W + TIME_W;

  // Sequencer. PREP forms the expiry, TEST drops past-time adds, then RD/CHK
  // walk the table, one entry per RD/CHK pair; RESP hands the item to the output.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_TEST = 6'b000100,
    S_RD   = 6'b001000,
    S_CHK  = 6'b010000,
    S_RESP = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // captured request
  logic [ACT_W-1:0]         act_q;
  logic signed [ID_W-1:0]   id_q;
  logic signed [TIME_W-1:0] tv_q;
  logic [NOW_W-1:0]         now_q;
  logic signed [TIME_W-1:0] exp_q, exp_d;

  // scan pointers: rd walks the table, wr is where kept entries land
  logic [CNT_W-1:0]  rd_q, rd_d, wr_q, wr_d, count_q, count_d;
  logic              copy_q, copy_d;     // id handled, rest only slides down
  logic              blocked_q, blocked_d;
  logic [STAT_W-1:0] status_q, status_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              out_blk_q;
  logic [STAT_W-1:0] out_stat_q;
  logic              out_load;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;
  logic signed [ID_W-1:0]   ent_id;
  logic signed [TIME_W-1:0] ent_exp;

  // shared arithmetic
  logic signed [TIME_W:0]   rel_sum;
  logic signed [TIME_W-1:0] now_s;
  logic                     ent_expired;
  logic                     ent_match;

  assign ent_id      = ram_rdata[ENT_W-1:TIME_W];
  assign ent_exp     = ram_rdata[TIME_W-1:0];
  assign now_s       = $signed({1'b0, now_q});
  assign rel_sum     = $signed({tv_q[TIME_W-1], tv_q}) + $signed({2'b00, now_q});
  assign ent_expired = (ent_exp != '0) && (ent_exp < now_s);
  assign ent_match   = (ent_id == id_q);

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || rsp_o.ready);

  tblt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    exp_d     = exp_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    count_d   = count_q;
    copy_d    = copy_q;
    blocked_d = blocked_q;
    status_d  = status_q;
    ram_we    = 1'b0;
    ram_waddr = wr_q[AW-1:0];
    ram_wdata = ram_rdata;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_PREP;
        end
      end

      S_PREP: begin
        rd_d      = '0;
        wr_d      = '0;
        copy_d    = 1'b0;
        blocked_d = 1'b0;
        status_d  = ST_ABSENT;
        if (act_q == ACT_ADD_REL) begin
          if (tv_q == TIME_PERM_REL) begin
            exp_d = '0;
          end else if (rel_sum > $signed({1'b0, TIME_MAX})) begin
            exp_d = TIME_MAX;
          end else begin
            exp_d = rel_sum[TIME_W-1:0];
          end
        end else begin
          exp_d = tv_q;
        end
        state_d = S_TEST;
      end

      S_TEST: begin
        // a nonzero expiry already in the past is dropped for adds
        if ((act_q == ACT_ADD_ABS || act_q == ACT_ADD_REL) &&
            exp_q != '0 && exp_q < now_s) begin
          status_d = ST_IGNORED;
          state_d  = S_RESP;
        end else begin
          state_d = S_RD;
        end
      end

      S_RD: begin
        if (rd_q == count_q) begin
          // end of table
          state_d = S_RESP;
          if (act_q == ACT_ADD_ABS || act_q == ACT_ADD_REL) begin
            if (count_q == CNT_W'(CAPACITY)) begin
              status_d = ST_FULL;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count_q[AW-1:0];
              ram_wdata = {id_q, exp_q};
              count_d   = count_q + 1'b1;
              status_d  = ST_ADDED;
            end
          end else begin
            count_d = wr_q;
          end
        end else begin
          state_d = S_CHK;
        end
      end

      S_CHK: begin
        state_d = S_RD;
        if (copy_q) begin
          ram_we = 1'b1;
          rd_d   = rd_q + 1'b1;
          wr_d   = wr_q + 1'b1;
        end else begin
          case (act_q)
            ACT_ADD_ABS, ACT_ADD_REL: begin
              if (ent_match) begin
                ram_we    = 1'b1;
                ram_waddr = rd_q[AW-1:0];
                ram_wdata = {id_q, exp_q};
                status_d  = ST_UPDATED;
                state_d   = S_RESP;
              end else begin
                rd_d = rd_q + 1'b1;
                wr_d = wr_q + 1'b1;
              end
            end
            ACT_REMOVE: begin
              rd_d = rd_q + 1'b1;
              if (ent_match) begin
                status_d = ST_FOUND;
                copy_d   = 1'b1;
              end else begin
                wr_d = wr_q + 1'b1;
              end
            end
            default: begin
              // query: expired entries are squeezed out as the scan passes
              if (ent_expired) begin
                rd_d = rd_q + 1'b1;
              end else begin
                ram_we = (wr_q != rd_q);
                rd_d   = rd_q + 1'b1;
                wr_d   = wr_q + 1'b1;
                if (ent_match) begin
                  blocked_d = 1'b1;
                  status_d  = ST_FOUND;
                  copy_d    = 1'b1;
                  if (wr_q == rd_q) begin
                    state_d = S_RESP;   // no gap, count stays
                  end
                end
              end
            end
          endcase
        end
      end

      S_RESP: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      copy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      copy_q      <= copy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      act_q <= req_i.action;
      id_q  <= req_i.entry_id;
      tv_q  <= req_i.time_value;
      now_q <= req_i.current_time;
    end
    exp_q     <= exp_d;
    blocked_q <= blocked_d;
    status_q  <= status_d;
    if (out_load) begin
      out_blk_q  <= blocked_q;
      out_stat_q <= status_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.is_blocked = out_blk_q;
  assign rsp_o.status     = out_stat_q;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_wr_behind_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_CHK) |-> (wr_q <= rd_q && rd_q <= count_q))
    else $error("scan pointers out of order");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q > $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
    else $error("entry count grew by more than one");

  a_ram_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == S_RD || state_q == S_CHK))
    else $error("table write outside scan");

  a_result_one_shot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> state_q == S_IDLE)
    else $error("sequencer did not return to idle after result");
`endif

endmodule
